FILE: sv/scd_pkg.sv
package scd_pkg;

  localparam int WINDOW_DEF   = 32;
  localparam int SUM_W        = 22;
  localparam int SUM_SHIFT    = 5;
  localparam int SAMPLE_W     = 16;
  localparam int TIME_W       = 32;
  localparam int LEVEL_CFG_W  = 15;
  localparam int TIMEOUT_W    = 16;
  localparam int LVL_W        = SUM_W - SUM_SHIFT;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [LEVEL_CFG_W-1:0] LOW_THR_RST  = 15'd1000;
  localparam logic [LEVEL_CFG_W-1:0] HIGH_LIM_RST = 15'd27000;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST  = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_START  = 1'b1;

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_START  = 1'b1
  } scd_cmd_t;

  typedef struct packed {
    scd_cmd_t                    cmd;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [TIME_W-1:0]           time_ms;
  } scd_item_t;

endpackage

FILE: sv/skin_contact_detector.sv
// Skin contact detector.
// Input channel (in_valid/in_ready): one request per sensor item, carrying
// in_operation (start or sample), in_light_sample and in_time_ms.
// Output channel (out_valid/out_ready): exactly one result per request, in
// order: warming_up, average_level, contact_lost, detecting.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 low level
// threshold, 1 high level limit, 2 loss timeout in ms; other indexes are
// dropped. Write only while no request is in flight.
// Path: a request accepted by the front is written into the input queue,
// the update unit takes it from there and registers its result in the
// output register, where a stalled receiver can hold it.
// Throughput: one request per cycle unless the receiver stalls; the update
// unit (a constant multiply, add and threshold compares) is combinational.
// A two-entry queue sits between the front and the update unit, and the
// result sits in an output register, so input keeps flowing while a result
// waits; a stalled receiver backs up the queue and drops in_ready once both
// entries are held.
// Reset (rst_n low, synchronous) empties the queue and output, clears
// count, sum, contact time and detecting, and restores register defaults.
module skin_contact_detector
  import scd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
)
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic signed [SAMPLE_W-1:0] in_light_sample,
  input  logic [TIME_W-1:0]          in_time_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_warming_up,
  output logic signed [SAMPLE_W-1:0] out_average_level,
  output logic                       out_contact_lost,
  output logic                       out_detecting,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  logic [LEVEL_CFG_W-1:0] low_thr_r;
  logic [LEVEL_CFG_W-1:0] high_lim_r;
  logic [TIMEOUT_W-1:0]   timeout_r;
  logic                   q_valid;
  logic                   q_pop;
  scd_item_t              q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= LOW_THR_RST;
      high_lim_r <= HIGH_LIM_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOW_THR:  low_thr_r  <= cfg_data[LEVEL_CFG_W-1:0];
        CFG_HIGH_LIM: high_lim_r <= cfg_data[LEVEL_CFG_W-1:0];
        CFG_TIMEOUT:  timeout_r  <= cfg_data[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  scd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_light_sample (in_light_sample),
    .in_time_ms      (in_time_ms),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_item          (q_item)
  );

  scd_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_item            (q_item),
    .low_thr           (low_thr_r),
    .high_lim          (high_lim_r),
    .timeout_ms        (timeout_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_warming_up    (out_warming_up),
    .out_average_level (out_average_level),
    .out_contact_lost  (out_contact_lost),
    .out_detecting     (out_detecting)
  );

endmodule

FILE: sv/scd_front.sv
module scd_front
  import scd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic signed [SAMPLE_W-1:0] in_light_sample,
  input  logic [TIME_W-1:0]          in_time_ms,
  output logic                       q_valid,
  input  logic                       q_pop,
  output scd_item_t                  q_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  scd_item_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  scd_item_t             item;
  logic                  push;
  logic                  pop;

  always_comb begin
    item.cmd     = (in_operation == OP_START) ? CMD_START : CMD_SAMPLE;
    item.sample  = in_light_sample;
    item.time_ms = in_time_ms;
  end

  assign in_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule

FILE: sv/scd_back.sv
module scd_back
  import scd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
)
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  scd_item_t                  q_item,
  input  logic [LEVEL_CFG_W-1:0]     low_thr,
  input  logic [LEVEL_CFG_W-1:0]     high_lim,
  input  logic [TIMEOUT_W-1:0]       timeout_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_warming_up,
  output logic signed [SAMPLE_W-1:0] out_average_level,
  output logic                       out_contact_lost,
  output logic                       out_detecting
);

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PROD_W = SUM_W + CNT_W;

  logic [CNT_W-1:0]           sample_cnt_r, sample_cnt_nxt;
  logic signed [SUM_W-1:0]    running_sum_r, running_sum_nxt;
  logic [TIME_W-1:0]          last_contact_r, last_contact_nxt;
  logic                       detect_r, detect_nxt;

  logic                       out_valid_r;
  logic                       out_warm_r, out_warm_nxt;
  logic signed [SAMPLE_W-1:0] out_level_r, out_level_nxt;
  logic                       out_lost_r, out_lost_nxt;
  logic                       out_det_r;

  logic [CNT_W:0]             cnt_inc;
  logic                       warm;
  logic signed [SUM_W-1:0]    sample_ext;
  logic signed [SUM_W-1:0]    sum_div;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]    smooth_sum;
  logic signed [LVL_W-1:0]    level;
  logic signed [LVL_W-1:0]    low_ext, high_ext;
  logic                       in_contact;
  logic [TIME_W-1:0]          diff;
  logic                       timed_out;
  logic                       fire;

  assign fire  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = fire;

  assign cnt_inc    = {1'b0, sample_cnt_r} + 1'b1;
  assign warm       = cnt_inc < (CNT_W + 1)'(WINDOW);
  assign sample_ext = {{(SUM_W - SAMPLE_W){q_item.sample[SAMPLE_W-1]}}, q_item.sample};
  assign sum_div    = running_sum_r >>> SUM_SHIFT;
  assign prod       = $signed({{CNT_W{sum_div[SUM_W-1]}}, sum_div})
                    * $signed({{SUM_W{1'b0}}, CNT_W'(WINDOW - 1)});
  assign smooth_sum = prod[SUM_W-1:0] + sample_ext;
  assign level      = smooth_sum[SUM_W-1:SUM_SHIFT];
  assign low_ext    = {{(LVL_W - LEVEL_CFG_W){1'b0}}, low_thr};
  assign high_ext   = {{(LVL_W - LEVEL_CFG_W){1'b0}}, high_lim};
  assign in_contact = (level > low_ext) && (level < high_ext);

  always_comb begin
    sample_cnt_nxt   = sample_cnt_r;
    running_sum_nxt  = running_sum_r;
    last_contact_nxt = last_contact_r;
    detect_nxt       = detect_r;
    out_warm_nxt     = 1'b0;
    out_level_nxt    = '0;
    out_lost_nxt     = 1'b0;
    diff             = '0;
    timed_out        = 1'b0;
    unique case (q_item.cmd)
      CMD_START: begin
        sample_cnt_nxt   = '0;
        running_sum_nxt  = '0;
        detect_nxt       = 1'b1;
        last_contact_nxt = q_item.time_ms;
        out_warm_nxt     = 1'b1;
      end
      CMD_SAMPLE: begin
        if (warm) begin
          sample_cnt_nxt   = cnt_inc[CNT_W-1:0];
          running_sum_nxt  = running_sum_r + sample_ext;
          last_contact_nxt = q_item.time_ms;
          out_warm_nxt     = 1'b1;
        end else begin
          sample_cnt_nxt  = CNT_W'(WINDOW);
          running_sum_nxt = smooth_sum;
          out_level_nxt   = smooth_sum[SUM_SHIFT+SAMPLE_W-1:SUM_SHIFT];
          if (in_contact) begin
            last_contact_nxt = q_item.time_ms;
          end
          diff      = q_item.time_ms - last_contact_nxt;
          timed_out = !diff[TIME_W-1] && (diff > {{(TIME_W - TIMEOUT_W){1'b0}}, timeout_ms});
          if (timed_out) begin
            out_lost_nxt = 1'b1;
            detect_nxt   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_cnt_r   <= '0;
      running_sum_r  <= '0;
      last_contact_r <= '0;
      detect_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (fire) begin
        sample_cnt_r   <= sample_cnt_nxt;
        running_sum_r  <= running_sum_nxt;
        last_contact_r <= last_contact_nxt;
        detect_r       <= detect_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_warm_r  <= out_warm_nxt;
      out_level_r <= out_level_nxt;
      out_lost_r  <= out_lost_nxt;
      out_det_r   <= detect_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_warming_up    = out_warm_r;
  assign out_average_level = out_level_r;
  assign out_contact_lost  = out_lost_r;
  assign out_detecting     = out_det_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sample_cnt_r <= CNT_W'(WINDOW))
    else $error("sample count past window");

  a_lost_clears_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_lost_r |-> !out_det_r && !out_warm_r)
    else $error("contact loss with detecting or warm-up set");

  a_warm_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_warm_r |-> out_level_r == '0)
    else $error("nonzero level during warm-up");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && q_item.cmd == CMD_START |=> out_valid_r && out_det_r && out_warm_r
      && sample_cnt_r == '0)
    else $error("start request result wrong");

endmodule
